// File: sv/base64url_codec_assert.svh
// assertion macros for the base64url codec
`ifndef BASE64URL_CODEC_ASSERT_SVH
`define BASE64URL_CODEC_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64U_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64url codec check failed");

// next-cycle implication, checked outside reset
`define B64U_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64url codec check failed");

`endif

// File: sv/b64u_pkg.sv
// shared types, constants and character mapping functions for the base64url codec
`default_nettype none

package b64u_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_USCORE  = 8'h5F;

    localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
    localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
    localparam logic [5:0] VAL_DASH       = 6'd62;
    localparam logic [5:0] VAL_USCORE     = 6'd63;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // position within a 3-byte or 4-character group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2,
        PH_3 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       msg_end;
    } result_t;

    // results of one input transaction, handed to the result buffer
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } load_t;

    function automatic logic [7:0] to_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < VAL_LOWER_BASE)
            r = CHAR_UPPER_A + {2'b00, v};
        else if (v < VAL_DIGIT_BASE)
            r = CHAR_LOWER_A + {2'b00, v - VAL_LOWER_BASE};
        else if (v < VAL_DASH)
            r = CHAR_DIGIT_0 + {2'b00, v - VAL_DIGIT_BASE};
        else if (v == VAL_DASH)
            r = CHAR_DASH;
        else
            r = CHAR_USCORE;
        return r;
    endfunction

    // unknown characters map to zero
    function automatic logic [5:0] from_char(input logic [7:0] c);
        logic [7:0] d;
        logic [5:0] r;
        d = 8'd0;
        r = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A;
            r = d[5:0];
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A;
            r = d[5:0] + VAL_LOWER_BASE;
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d = c - CHAR_DIGIT_0;
            r = d[5:0] + VAL_DIGIT_BASE;
        end
        else if (c == CHAR_DASH)
            r = VAL_DASH;
        else if (c == CHAR_USCORE)
            r = VAL_USCORE;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/b64u_step.sv
// combinational encode/decode step for one registered transaction
`default_nettype none

module b64u_step (
    input  wire logic             direction,
    input  wire b64u_pkg::phase_t phase,
    input  wire logic [7:0]       partial,
    input  wire logic [7:0]       value,
    input  wire logic             last,
    output b64u_pkg::load_t       ld,
    output b64u_pkg::phase_t      phase_next,
    output logic [7:0]            partial_next
);
    import b64u_pkg::*;

    logic [5:0] x;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [1:0] n;

    assign x = from_char(value);

    always_comb
    begin
        r0           = 8'd0;
        r1           = 8'd0;
        n            = 2'd0;
        phase_next   = phase;
        partial_next = partial;
        if (direction == DIR_ENCODE)
        begin
            unique case (phase)
                PH_1:
                begin
                    r0           = to_char(partial[5:0] + {2'b00, value[7:4]});
                    partial_next = {2'b00, value[3:0], 2'b00};
                    phase_next   = PH_2;
                    n            = 2'd1;
                end
                PH_2:
                begin
                    r0           = to_char(partial[5:0] | {4'b0000, value[7:6]});
                    r1           = to_char(value[5:0]);
                    partial_next = 8'd0;
                    phase_next   = PH_0;
                    n            = 2'd2;
                end
                PH_0, PH_3:
                begin
                    r0           = to_char(value[7:2]);
                    partial_next = {2'b00, value[1:0], 4'b0000};
                    phase_next   = PH_1;
                    n            = 2'd1;
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
            // flush the pending partial character at message end
            if (last && phase_next != PH_0)
            begin
                r1 = to_char(partial_next[5:0]);
                n  = 2'd2;
            end
        end
        else
        begin
            unique case (phase)
                PH_0:
                begin
                    partial_next = {x, 2'b00};
                    phase_next   = PH_1;
                end
                PH_1:
                begin
                    r0           = partial | {6'b000000, x[5:4]};
                    partial_next = {x[3:0], 4'b0000};
                    phase_next   = PH_2;
                    n            = 2'd1;
                end
                PH_2:
                begin
                    r0           = partial | {4'b0000, x[5:2]};
                    partial_next = {x[1:0], 6'b000000};
                    phase_next   = PH_3;
                    n            = 2'd1;
                end
                PH_3:
                begin
                    r0           = partial | {2'b00, x};
                    partial_next = 8'd0;
                    phase_next   = PH_0;
                    n            = 2'd1;
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
        end
        if (last)
        begin
            phase_next   = PH_0;
            partial_next = 8'd0;
        end
    end

    always_comb
    begin
        ld.count         = n;
        ld.res0.value    = r0;
        ld.res1.value    = r1;
        ld.res0.run_end  = (n == 2'd1);
        ld.res0.msg_end  = (n == 2'd1) && last;
        ld.res1.run_end  = 1'b1;
        ld.res1.msg_end  = last;
    end

endmodule

`default_nettype wire

// File: sv/b64u_outbuf.sv
// two-entry result buffer that drains one result per cycle while out_ready is high
`default_nettype none

module b64u_outbuf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load_en,
    input  wire b64u_pkg::load_t ld,
    output logic                 free,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output b64u_pkg::result_t    head
);
    import b64u_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot0_reg;
    // empty now, or emptied by the result leaving this cycle
    assign free      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (out_valid && out_ready)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (load_en)
        begin
            cnt_next   = ld.count;
            slot0_next = (ld.count == 2'd2) ? ld.res0 : ld.res0;
            slot1_next = ld.res1;
            if (ld.count == 2'd1)
                slot0_next = ld.res0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// File: sv/base64url_codec.sv
// top level of the streaming URL-safe base64 codec
// Streaming unpadded base64url codec. cfg_we/cfg_wdata set the direction
// (0 encode bytes to characters, 1 decode characters to bytes) and clear the
// group phase; write it only while the block is idle. Each input transaction
// is captured in an input register, run through one combinational step and
// loaded as zero, one or two results into a two-entry result buffer, which
// presents one result per cycle on the output while out_ready is high.
// Decoding sustains one input transaction per cycle while out_ready is high;
// encoding holds the next one while a byte's two characters both sit in the
// result buffer, set by its single output port. A result shows on the output
// the cycle after its item leaves the input register. On in_last the encoder
// flushes its partial character and the decoder drops its partial byte;
// out_run_end marks the last result of each item, out_msg_end that of the
// message (a decode last item with no byte carries no mark).
`default_nettype none

module base64url_codec (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_value,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_value,
    output logic            out_run_end,
    output logic            out_msg_end
);
    import b64u_pkg::*;

    `include "base64url_codec_assert.svh"

    // input register
    logic       a_valid_reg;
    logic       a_valid_next;
    logic [7:0] a_value_reg;
    logic       a_last_reg;
    logic       a_move;

    // codec state
    logic       direction_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] partial_reg;
    logic [7:0] partial_next;

    load_t      ld;
    result_t    head;
    logic       buf_free;

    // item leaves the input register once the buffer can take its results
    assign a_move   = a_valid_reg && buf_free;
    assign in_ready = !a_valid_reg || a_move;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_valid && in_ready)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_value_reg <= in_value;
            a_last_reg  <= in_last;
        end
    end

    // direction write restarts the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            phase_reg     <= PH_0;
            partial_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
            phase_reg     <= PH_0;
            partial_reg   <= 8'd0;
        end
        else if (a_move)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

    b64u_step u_step (
        .direction    (direction_reg),
        .phase        (phase_reg),
        .partial      (partial_reg),
        .value        (a_value_reg),
        .last         (a_last_reg),
        .ld           (ld),
        .phase_next   (phase_next),
        .partial_next (partial_next)
    );

    b64u_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (a_move),
        .ld        (ld),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_value   = head.value;
    assign out_run_end = head.run_end;
    assign out_msg_end = head.msg_end;

    // message end is always the last result of its transaction
    `B64U_ASSERT_NOW(a_msg_end_run_end, out_valid && out_msg_end, out_run_end)
    // a last transaction leaves the group at phase zero
    `B64U_ASSERT_NEXT(a_last_clears, a_move && a_last_reg,
        phase_reg == PH_0 && partial_reg == 8'd0)
    // the encoder never reaches the fourth phase
    `B64U_ASSERT_NOW(a_enc_no_ph3, direction_reg == DIR_ENCODE, phase_reg != PH_3)
    // every encoded byte yields at least one character
    `B64U_ASSERT_NOW(a_enc_emits, a_move && direction_reg == DIR_ENCODE,
        ld.count != 2'd0)

endmodule

`default_nettype wire
